FILE: hdl/pqkr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pqkr_pkg
// Types and constants shared by the process queue with keyed removal.
// ----------------------------------------------------------------------------
package pqkr_pkg;
  localparam int QueueDepth = 16;
  localparam int NameBytes  = 8;
  localparam int IdxW       = $clog2(QueueDepth);
  localparam int CntW       = $clog2(QueueDepth + 1);
  localparam int RecW       = 64 + 8 + 22 + 16;
  localparam logic [63:0] NameMask =
      (NameBytes >= 8) ? 64'hFFFF_FFFF_FFFF_FFFF :
      ((64'd1 << (8 * NameBytes)) - 64'd1);

  typedef enum logic [1:0] {
    REQ_PUSH = 2'd0, REQ_POP = 2'd1, REQ_DEL_NAME = 2'd2, REQ_DEL_PID = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_EMPTY = 2'd1, ST_FULL = 2'd2, ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SHIFT_RD, S_SHIFT_WR, S_DONE
  } state_t;

  typedef struct packed {
    logic [63:0] name;
    logic [7:0]  priority_v;
    logic [21:0] pid;
    logic [15:0] runtime;
  } rec_t;
endpackage
`default_nettype wire

FILE: hdl/pqkr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pqkr_ram
// Record store with one write port and one read port; the read is registered.
// ----------------------------------------------------------------------------
module pqkr_ram (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [pqkr_pkg::IdxW-1:0] waddr,
  input  wire pqkr_pkg::rec_t          wdata,
  input  wire logic [pqkr_pkg::IdxW-1:0] raddr,
  output pqkr_pkg::rec_t               rdata
);
  import pqkr_pkg::*;
  rec_t mem [QueueDepth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hdl/process_queue_keyed_removal_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// process_queue_keyed_removal_unit
// Bounded FIFO of process records with pop and removal by name or pid.
// ----------------------------------------------------------------------------
// Channel  Dir  Contents
// s_axis   in   request: type in tuser, record or key in tdata
// m_axis   out  result: status in tuser, record and fill level in tdata
//
// Push writes its record as it is accepted. Pop and delete read one slot a cycle
// from the head until a match, then close up the queue, reading and then
// writing each moved slot in turn through the memory.
// Reset clears the count and the control; slot contents are left as they are.
// A result waits in the output register while m_axis_tready is low.
// ----------------------------------------------------------------------------
module process_queue_keyed_removal_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // key_name[63:0], entry_priority[71:64], entry_pid[93:72],
  // entry_runtime[109:94], zero [111:110]
  input  wire logic [111:0] s_axis_tdata,
  // req_type[1:0]
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // out_name[63:0], out_priority[71:64], out_pid[93:72],
  // out_runtime[109:94], fill_level[114:110], zero [119:115]
  output logic [119:0]      m_axis_tdata,
  // status[1:0]
  output logic [1:0]        m_axis_tuser
);
  import pqkr_pkg::*;

  state_t state, state_next;
  req_t   req;
  rec_t   key;
  logic [CntW-1:0] count;
  logic [CntW-1:0] idx;
  rec_t   res_rec;
  status_t res_status;
  logic   we;
  logic [IdxW-1:0] waddr, raddr;
  rec_t   wdata, rdata;
  logic   hit;
  logic   out_valid;
  logic [CntW-1:0] idx_inc;

  assign idx_inc = idx + 1'b1;

  pqkr_ram u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign hit = (req == REQ_POP) ||
               (req == REQ_DEL_NAME && rdata.name == key.name) ||
               (req == REQ_DEL_PID && rdata.pid == key.pid);

  assign s_axis_tready = (state == S_IDLE) && !out_valid;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          if (req_t'(s_axis_tuser) == REQ_PUSH) state_next = S_DONE;
          else if (count == '0) state_next = S_DONE;
          else state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) state_next = (idx_inc < count) ? S_SHIFT_RD : S_DONE;
        else if (idx_inc >= count) state_next = S_DONE;
      end
      S_SHIFT_RD: state_next = S_SHIFT_WR;
      // In the shift loop count is already one less, so idx_inc < count stops at the new last slot.
      S_SHIFT_WR: state_next = (idx_inc < count) ? S_SHIFT_RD : S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx[IdxW-1:0];
    wdata = rdata;
    raddr = idx[IdxW-1:0];
    case (state)
      S_IDLE: begin
        raddr = '0;
        waddr = count[IdxW-1:0];
        wdata.name       = s_axis_tdata[63:0] & NameMask;
        wdata.priority_v = s_axis_tdata[71:64];
        wdata.pid        = s_axis_tdata[93:72];
        wdata.runtime    = s_axis_tdata[109:94];
        we = s_axis_tvalid && s_axis_tready &&
             req_t'(s_axis_tuser) == REQ_PUSH && count < CntW'(QueueDepth);
      end
      S_SCAN: raddr = idx_inc[IdxW-1:0];
      S_SHIFT_RD: raddr = idx_inc[IdxW-1:0];
      S_SHIFT_WR: begin
        we = 1'b1;
        raddr = idx_inc[IdxW-1:0] + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && m_axis_tready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          idx <= '0;
          if (s_axis_tvalid && s_axis_tready) begin
            req <= req_t'(s_axis_tuser);
            key.name <= s_axis_tdata[63:0] & NameMask;
            key.pid  <= s_axis_tdata[93:72];
            res_rec  <= '0;
            case (req_t'(s_axis_tuser))
              REQ_PUSH: begin
                if (count < CntW'(QueueDepth)) begin
                  res_status <= ST_OK;
                  count <= count + 1'b1;
                end else begin
                  res_status <= ST_FULL;
                end
              end
              REQ_POP: res_status <= (count == '0) ? ST_EMPTY : ST_NOTFOUND;
              default: res_status <= ST_NOTFOUND;
            endcase
          end
        end
        S_SCAN: begin
          if (hit) begin
            res_rec <= rdata;
            res_status <= ST_OK;
            count <= count - 1'b1;
          end else begin
            idx <= idx_inc;
          end
        end
        S_SHIFT_WR: idx <= idx_inc;
        S_DONE: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = res_status;
  assign m_axis_tdata  = {5'd0, count, res_rec.runtime, res_rec.pid,
                          res_rec.priority_v, res_rec.name};
endmodule
`default_nettype wire
